### sv/mi3_pkg.sv
// Shared constants, types and index tables for the 3x3 matrix inverse core.
// No dependencies; imported by the front, queue, back end, top and testbench.
package mi3_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned ELEM_W          = 16;
  localparam int unsigned PROD_W          = 32;
  localparam int unsigned COF_W           = 33;
  localparam int unsigned DET_W           = 49;
  localparam int unsigned NUM_W           = 57;
  localparam int unsigned Q_W             = 32;
  localparam int unsigned FRAC_SHIFT      = 24;
  localparam int unsigned DIV_STAGES      = Q_W;

  // Cofactor C[k] = A[M_I[k]] * A[M_J[k]] - A[N_I[k]] * A[N_J[k]], k = r*3+c,
  // element indexes are row*3+col; checkerboard signs are folded in.
  localparam int unsigned M_I [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int unsigned M_J [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int unsigned N_I [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int unsigned N_J [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  // One queue entry: nine cofactors and the determinant.
  typedef struct packed {
    logic [8:0][COF_W-1:0] cof;
    logic [DET_W-1:0]      det;
  } mi3_work_t;

  // One divider lane.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             ovf;
  } mi3_lane_t;

  // One divider pipeline stage.
  typedef struct packed {
    mi3_lane_t [8:0]  lane;
    logic [DET_W-1:0] dabs;
    logic             sing;
  } mi3_stage_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic head_valid;
    logic pop;
  } mi3_qctl_t;

endpackage

### sv/mi3_in_if.sv
// Input channel interface: one 3x3 Q8.8 matrix per transaction.
// Depends on nothing.
interface mi3_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

### sv/mi3_out_if.sv
// Result channel interface: one Q16.16 inverse plus singular flag per transaction.
// Depends on nothing.
interface mi3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] q00, q01, q02, q10, q11, q12, q20, q21, q22;
  logic               singular;

  modport source (output valid, q00, q01, q02, q10, q11, q12, q20, q21, q22,
                  singular, input ready);
  modport sink   (input valid, q00, q01, q02, q10, q11, q12, q20, q21, q22,
                  singular, output ready);
endinterface

### sv/matrix_inverse_3x3_core.sv
// Top level of the 3x3 adjugate matrix inverse: front end, work queue, back end.
// Depends on mi3_pkg, mi3_in_if, mi3_out_if, mi3_front, mi3_queue, mi3_back.
//
//   channel | dir | transaction
//   in_ch   | in  | a00..a22, signed Q8.8
//   out_ch  | out | q00..q22 signed Q16.16 saturated, singular
//
// One matrix per cycle sustained while the output does not stall; path: 3 front
// stages, queue, prep, 32 divider stages of one quotient bit each, output register.
// Reset: rst_n synchronous, clears queue, credits and valid bits only.
// Output stall freezes the back end; the front keeps accepting while the
// queue has credits (QUEUE_DEPTH transactions in the front stages or queued).
module matrix_inverse_3x3_core import mi3_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mi3_in_if.sink    in_ch,
  mi3_out_if.source out_ch
);

  logic      push;
  mi3_work_t push_data;
  mi3_work_t head;
  mi3_qctl_t q2b, b2q;

  mi3_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .pop       (b2q.pop),
    .push      (push),
    .push_data (push_data)
  );

  mi3_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .head      (head),
    .qctl_in   (b2q),
    .qctl_out  (q2b)
  );

  mi3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qctl_in  (q2b),
    .qctl_out (b2q),
    .out_ch   (out_ch)
  );

endmodule

### sv/mi3_front.sv
// Front end: accepts matrices, forms cofactors and determinant in three stages.
// Depends on mi3_pkg and mi3_in_if; holds credits for the work queue.
module mi3_front import mi3_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mi3_in_if.sink    in_ch,
  input  logic      pop,
  output logic      push,
  output mi3_work_t push_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     acc;
  logic signed [ELEM_W-1:0] e [9];
  logic signed [PROD_W-1:0] pm_r [9];
  logic signed [PROD_W-1:0] pn_r [9];
  logic signed [ELEM_W-1:0] a0_r  [3];
  logic signed [ELEM_W-1:0] a0b_r [3];
  logic signed [COF_W-1:0]  cof_r  [9];
  logic signed [COF_W-1:0]  cofb_r [9];
  logic signed [DET_W-1:0]  dp_r [3];
  logic                     v1_r, v2_r, v3_r;

  always_comb begin
    e[0] = in_ch.a00; e[1] = in_ch.a01; e[2] = in_ch.a02;
    e[3] = in_ch.a10; e[4] = in_ch.a11; e[5] = in_ch.a12;
    e[6] = in_ch.a20; e[7] = in_ch.a21; e[8] = in_ch.a22;
  end

  // Credits cover every transaction in the front stages or waiting in the queue
  assign in_ch.ready = (cnt_r < CNT_W'(QUEUE_DEPTH));
  assign acc         = in_ch.valid & in_ch.ready;
  assign cnt_nxt     = cnt_r + CNT_W'(acc) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      v1_r  <= acc;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
    end
  end

  // Stage 1: minor products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      pm_r[k] <= e[M_I[k]] * e[M_J[k]];
      pn_r[k] <= e[N_I[k]] * e[N_J[k]];
    end
    for (int j = 0; j < 3; j++) a0_r[j] <= e[j];
  end

  // Stage 2: cofactors
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) cof_r[k] <= COF_W'(pm_r[k]) - COF_W'(pn_r[k]);
    for (int j = 0; j < 3; j++) a0b_r[j] <= a0_r[j];
  end

  // Stage 3: first-row determinant terms
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) dp_r[j] <= DET_W'(a0b_r[j]) * DET_W'(cof_r[j]);
    for (int k = 0; k < 9; k++) cofb_r[k] <= cof_r[k];
  end

  // Determinant sum goes straight into the queue write
  always_comb begin
    push = v3_r;
    for (int k = 0; k < 9; k++) push_data.cof[k] = cofb_r[k];
    push_data.det = dp_r[0] + dp_r[1] + dp_r[2];
  end

endmodule

### sv/mi3_queue.sv
// Work queue between front and back end: register FIFO of cofactor sets.
// Depends on mi3_pkg.
module mi3_queue import mi3_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mi3_work_t push_data,
  output mi3_work_t head,
  input  mi3_qctl_t qctl_in,
  output mi3_qctl_t qctl_out
);

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  mi3_work_t        mem_r [QUEUE_DEPTH];
  logic [AW-1:0]    wptr_r, rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign pop                 = qctl_in.pop;
  assign head                = mem_r[rptr_r];
  assign qctl_out.head_valid = (cnt_r != '0);
  assign qctl_out.pop        = pop;

  // Pointers wrap at the depth, which need not be a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= (wptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (pop)  rptr_r <= (rptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule

### sv/mi3_back.sv
// Back end: sign split, 32-stage restoring divider per lane, saturation, output.
// Depends on mi3_pkg and mi3_out_if.
module mi3_back import mi3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mi3_work_t head,
  input  mi3_qctl_t qctl_in,
  output mi3_qctl_t qctl_out,
  mi3_out_if.source out_ch
);

  logic             en;
  logic             pop;
  logic             vld_r [DIV_STAGES+1];
  mi3_stage_t       stg_r [DIV_STAGES+1];
  mi3_stage_t       prep;
  logic             out_valid_r;
  logic [Q_W-1:0]   res [9];
  logic [Q_W-1:0]   q_r [9];
  logic             sing_r;

  // Whole pipeline moves unless the output holds an untaken result
  assign en                  = !out_valid_r || out_ch.ready;
  assign pop                 = qctl_in.head_valid && en;
  assign qctl_out.pop        = pop;
  assign qctl_out.head_valid = qctl_in.head_valid;

  // Prep: magnitudes, result sign and overflow check; output (r,c) uses C[c][r]
  always_comb begin
    logic signed [DET_W-1:0] det;
    logic signed [COF_W-1:0] cof;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        anum;
    det       = head.det;
    prep.sing = (det == '0);
    prep.dabs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        cof  = head.cof[c*3+r];
        num  = NUM_W'(cof) <<< FRAC_SHIFT;
        anum = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        prep.lane[r*3+c].rem = anum;
        prep.lane[r*3+c].quo = '0;
        prep.lane[r*3+c].neg = cof[COF_W-1] ^ det[DET_W-1];
        prep.lane[r*3+c].ovf =
          (NUM_W'(anum[NUM_W-1:Q_W]) >= NUM_W'(prep.dabs));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) stg_r[0] <= prep;
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int unsigned B = Q_W - 1 - s;
    mi3_stage_t nxt;

    always_comb begin
      logic [NUM_W-1:0] dsh;
      nxt = stg_r[s];
      dsh = NUM_W'(stg_r[s].dabs) << B;
      for (int l = 0; l < 9; l++) begin
        if ((stg_r[s].lane[l].rem >> B) >= NUM_W'(stg_r[s].dabs)) begin
          nxt.lane[l].rem    = stg_r[s].lane[l].rem - dsh;
          nxt.lane[l].quo[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) stg_r[s+1] <= nxt;
    end
  end

  // Sign restore and saturation; singular forces zeros
  always_comb begin
    mi3_lane_t ln;
    for (int l = 0; l < 9; l++) begin
      ln = stg_r[DIV_STAGES].lane[l];
      if (stg_r[DIV_STAGES].sing) begin
        res[l] = '0;
      end else if (ln.neg) begin
        if (ln.ovf || (ln.quo > {1'b1, {(Q_W-1){1'b0}}})) begin
          res[l] = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
          res[l] = -ln.quo;
        end
      end else begin
        if (ln.ovf || ln.quo[Q_W-1]) begin
          res[l] = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
          res[l] = ln.quo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 9; l++) q_r[l] <= res[l];
      sing_r <= stg_r[DIV_STAGES].sing;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.q00      = q_r[0];
  assign out_ch.q01      = q_r[1];
  assign out_ch.q02      = q_r[2];
  assign out_ch.q10      = q_r[3];
  assign out_ch.q11      = q_r[4];
  assign out_ch.q12      = q_r[5];
  assign out_ch.q20      = q_r[6];
  assign out_ch.q21      = q_r[7];
  assign out_ch.q22      = q_r[8];
  assign out_ch.singular = sing_r;

endmodule

### verif/mi3_checker.sv
`timescale 1ns / 100ps
// Watches the matrix inverse core's channels, predicts each inverse and compares it.
// Depends on mi3_in_if and mi3_out_if.
module mi3_checker (
  input  logic      clk,
  input  logic      rst_n,
  mi3_in_if         in_ch,
  mi3_out_if        out_ch,
  output int        fail_count,
  output int        pending,
  output int        inverse_count,
  output int        singular_count,
  output int        saturated_count
);

  typedef struct {
    logic signed [31:0] q [9];
    logic               singular;
  } inverse_t;

  inverse_t expected_inverses [$];

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Adjugate over determinant, exact in 64-bit arithmetic.
  function automatic inverse_t invert(input logic signed [15:0] m [9]);
    inverse_t res;
    longint a [3][3];
    longint cof [3][3];
    longint det;
    longint quot;
    for (int k = 0; k < 9; k++) a[k/3][k%3] = longint'(m[k]);
    cof[0][0] =  (a[1][1]*a[2][2] - a[1][2]*a[2][1]);
    cof[0][1] = -(a[1][0]*a[2][2] - a[1][2]*a[2][0]);
    cof[0][2] =  (a[1][0]*a[2][1] - a[1][1]*a[2][0]);
    cof[1][0] = -(a[0][1]*a[2][2] - a[0][2]*a[2][1]);
    cof[1][1] =  (a[0][0]*a[2][2] - a[0][2]*a[2][0]);
    cof[1][2] = -(a[0][0]*a[2][1] - a[0][1]*a[2][0]);
    cof[2][0] =  (a[0][1]*a[1][2] - a[0][2]*a[1][1]);
    cof[2][1] = -(a[0][0]*a[1][2] - a[0][2]*a[1][0]);
    cof[2][2] =  (a[0][0]*a[1][1] - a[0][1]*a[1][0]);
    det = a[0][0]*cof[0][0] + a[0][1]*cof[0][1] + a[0][2]*cof[0][2];
    res.singular = (det == 0);
    for (int k = 0; k < 9; k++) begin
      if (det == 0) begin
        res.q[k] = '0;
      end else begin
        // SV division truncates toward zero
        quot = (cof[k%3][k/3] * 64'sd16777216) / det;
        res.q[k] = clamp_q16(quot);
      end
    end
    return res;
  endfunction

  // Predict on every accepted input, compare every accepted result
  always @(posedge clk) begin
    logic signed [15:0] m [9];
    logic signed [31:0] got [9];
    inverse_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
      inverse_count <= 0;
      singular_count <= 0;
      saturated_count <= 0;
      expected_inverses.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        m = '{in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
              in_ch.a20, in_ch.a21, in_ch.a22};
        want = invert(m);
        if (want.singular) singular_count <= singular_count + 1;
        for (int k = 0; k < 9; k++)
          if (want.q[k] == 32'sh7fffffff || want.q[k] == 32'sh80000000) begin
            saturated_count <= saturated_count + 1;
            break;
          end
        expected_inverses.insert(expected_inverses.size(), want);
      end
      if (out_ch.valid && out_ch.ready) begin
        inverse_count <= inverse_count + 1;
        if (expected_inverses.size() == 0) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          want = expected_inverses.pop_front();
          got = '{out_ch.q00, out_ch.q01, out_ch.q02, out_ch.q10, out_ch.q11, out_ch.q12,
                  out_ch.q20, out_ch.q21, out_ch.q22};
          for (int k = 0; k < 9; k++)
            if (got[k] !== want.q[k]) begin
              $error("q%0d%0d: expected %0d, got %0d", k/3, k%3, want.q[k], got[k]);
              errs++;
            end
          if (out_ch.singular !== want.singular) begin
            $error("singular: expected %0b, got %0b", want.singular, out_ch.singular);
            errs++;
          end
        end
      end
      // One update per edge, however many fields mismatched
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

  assign pending = expected_inverses.size();

endmodule

### verif/matrix_inverse_3x3_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for matrix_inverse_3x3_core: drives matrices, stalls the result side.
// Depends on mi3_pkg, mi3_in_if, mi3_out_if, matrix_inverse_3x3_core and mi3_checker.
module matrix_inverse_3x3_core_tb;
  import mi3_pkg::*;

  localparam int RANDOM_MATRICES = 1530;
  localparam int CALM_TAIL       = 200;
  localparam int LATENCY         = 38;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b0;
  logic stall_on = 1'b1;
  int   fail_count, pending, inverse_count, singular_count, saturated_count;

  mi3_in_if  in_ch ();
  mi3_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  always #6 clk = ~clk;

  matrix_inverse_3x3_core DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  mi3_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .inverse_count(inverse_count),
    .singular_count(singular_count), .saturated_count(saturated_count)
  );

  // Random elements: mostly moderate, some full range or extreme
  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'(int'($urandom_range(0, 8)) - 4);
      3, 4:    return 16'($urandom());
      default: return 16'(int'($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  // Send one matrix: hold until accepted, then maybe idle for a burst
  task automatic send_matrix(input logic signed [15:0] m [9], input bit may_idle);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    {in_ch.a00, in_ch.a01, in_ch.a02} <= {m[0], m[1], m[2]};
    {in_ch.a10, in_ch.a11, in_ch.a12} <= {m[3], m[4], m[5]};
    {in_ch.a20, in_ch.a21, in_ch.a22} <= {m[6], m[7], m[8]};
    do @(posedge clk); while (!in_ch.ready);
    if (may_idle && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10) - 1) @(negedge clk);
    end
  endtask

  // Result side stalls in bursts until the calm tail
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        sink_ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic signed [15:0] m [9];
    logic signed [15:0] r;
    in_ch.valid = 1'b0;
    {in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
     in_ch.a20, in_ch.a21, in_ch.a22} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: identity, zero, singular, extremes, saturation, negatives
    send_matrix('{256, 0, 0, 0, 256, 0, 0, 0, 256}, 1'b0);
    send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
    send_matrix('{256, 512, 768, 512, 1024, 1536, 1, 2, 3}, 1'b0);
    send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b0);
    send_matrix('{-1, 0, 0, 0, -1, 0, 0, 0, -1}, 1'b0);
    send_matrix('{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff}, 1'b0);
    send_matrix('{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}, 1'b0);
    send_matrix('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff}, 1'b0);
    send_matrix('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000}, 1'b0);
    send_matrix('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0);
    send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 1'b0);
    send_matrix('{0, 256, 0, 0, 0, 256, 256, 0, 0}, 1'b0);
    send_matrix('{2, 1, 0, 1, 2, 1, 0, 1, 2}, 1'b0);
    send_matrix('{16'sh7fff, 0, 0, 0, 1, 0, 0, 0, -1}, 1'b0);
    send_matrix('{16'sh7fff, 16'sh7ffe, 0, 16'sh7ffe, 16'sh7ffd, 0, 0, 0, 1}, 1'b0);
    send_matrix('{16'sh5555, 16'shaaaa, 0, 0, 16'sh5555, 16'shaaaa,
                  16'shaaaa, 0, 16'sh5555}, 1'b0);

    // Random: mostly general, some with a dependent or zero row to force singular, some small near-diagonal
    for (int n = 0; n < RANDOM_MATRICES; n++) begin
      if (n == RANDOM_MATRICES - CALM_TAIL) stall_on = 1'b0;
      foreach (m[k]) m[k] = rand_elem();
      case ($urandom_range(0, 9))
        0: for (int c = 0; c < 3; c++) m[6+c] = m[c];
        1: for (int c = 0; c < 3; c++) m[3+c] = -m[c];
        2: for (int c = 0; c < 3; c++) m[c] = 0;
        3: begin
          r = 16'(int'($urandom_range(0, 8)) - 4);
          foreach (m[k]) m[k] = (k % 4 == 0) ? r : 16'(int'($urandom_range(0, 2)) - 1);
        end
        default: ;
      endcase
      send_matrix(m, n < RANDOM_MATRICES - CALM_TAIL);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d inverses: %0d singular, %0d with saturated elements.",
             inverse_count, singular_count, saturated_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 200000);
    $display("Timed out with %0d results outstanding.", pending);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
sv/mi3_pkg.sv
sv/mi3_in_if.sv
sv/mi3_out_if.sv
sv/mi3_front.sv
sv/mi3_queue.sv
sv/mi3_back.sv
sv/matrix_inverse_3x3_core.sv
verif/mi3_checker.sv
verif/matrix_inverse_3x3_core_tb.sv
